### src/rbp_pkg.sv
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared types and constants for the reference-counted buffer pool.
// ----------------------------------------------------------------------------
package rbp_pkg;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_ADDREF  = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_QUERY   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FREE  = 2'd2,
		ST_SAT   = 2'd3
	} status_t;

	localparam int HANDLE_W = 5;
	localparam int COUNT_W  = 8;
	localparam int LEVEL_W  = 6;
	localparam int DROP_W   = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
	localparam logic [DROP_W-1:0]  DROP_MAX  = '1;

	typedef struct packed {
		logic [1:0]          command;
		logic [HANDLE_W-1:0] handle;
	} rbp_in_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] granted_handle;
		logic [COUNT_W-1:0]  ref_count;
		logic [LEVEL_W-1:0]  free_count;
		logic [LEVEL_W-1:0]  in_use_count;
		logic [DROP_W-1:0]   dropped_count;
	} rbp_out_t;

	// requests from the command stage to the free FIFO
	typedef struct packed {
		logic pop;
		logic push;
	} rbp_fifo_req_t;

	typedef struct packed {
		logic empty;
		logic full;
	} rbp_fifo_sts_t;

endpackage

### src/rbp_free_fifo.sv
// ----------------------------------------------------------------------------
// rbp_free_fifo
// Circular FIFO of free handles in a synchronous RAM. Entries not yet pushed
// read as their own index, so the initial 0..N-1 contents need no fill pass.
// ----------------------------------------------------------------------------
module rbp_free_fifo
	import rbp_pkg::*;
#(
	parameter int NUM_BUFFERS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rd_en,
	input  logic                                 adv,
	input  rbp_fifo_req_t                        req,
	input  logic [$clog2(NUM_BUFFERS)-1:0]       push_data,
	output logic [$clog2(NUM_BUFFERS)-1:0]       head_data,
	output rbp_fifo_sts_t                        sts,
	output logic [$clog2(NUM_BUFFERS+1)-1:0]     level,
	output logic [$clog2(NUM_BUFFERS+1)-1:0]     level_n
);

	localparam int AW = $clog2(NUM_BUFFERS);
	localparam int LW = $clog2(NUM_BUFFERS + 1);
	localparam logic [AW-1:0] LAST = AW'(NUM_BUFFERS - 1);
	localparam logic [LW-1:0] FULL = LW'(NUM_BUFFERS);

	logic [AW-1:0] mem [NUM_BUFFERS];
	logic [AW-1:0] head_q, tail_q, head_nx;
	logic [LW-1:0] level_q, fill_q;
	logic [AW-1:0] rd_s1, rd_addr_s1;
	logic          byp_v_q;
	logic [AW-1:0] byp_addr_q, byp_data_q;
	logic          do_pop, do_push;

	assign sts.empty = (level_q == '0);
	assign sts.full  = (level_q == FULL);
	assign do_pop    = adv && req.pop && !sts.empty;
	assign do_push   = adv && req.push && !sts.full;
	assign head_nx   = do_pop ? ((head_q == LAST) ? '0 : head_q + 1'b1) : head_q;
	assign level     = level_q;
	assign level_n   = level_q + LW'(do_push) - LW'(do_pop);

	// last write wins; slots beyond the fill mark still hold their reset index
	always_comb begin
		priority if (byp_v_q && byp_addr_q == rd_addr_s1) begin
			head_data = byp_data_q;
		end else if (LW'(rd_addr_s1) < fill_q) begin
			head_data = rd_s1;
		end else begin
			head_data = rd_addr_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			level_q    <= FULL;
			fill_q     <= '0;
			byp_v_q    <= 1'b0;
			byp_addr_q <= '0;
			byp_data_q <= '0;
		end else begin
			head_q  <= head_nx;
			level_q <= level_n;
			if (do_push) begin
				tail_q     <= (tail_q == LAST) ? '0 : tail_q + 1'b1;
				byp_v_q    <= 1'b1;
				byp_addr_q <= tail_q;
				byp_data_q <= push_data;
				if (fill_q != FULL) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail_q] <= push_data;
		end
		if (rd_en) begin
			rd_s1      <= mem[head_nx];
			rd_addr_s1 <= head_nx;
		end
	end

endmodule

### src/refcounted_buffer_pool_core.sv
// ----------------------------------------------------------------------------
// refcounted_buffer_pool_core
// Buffer handle pool: free FIFO plus per-handle reference counts.
// ----------------------------------------------------------------------------
// Takes one command beat per cycle (allocate, add reference, release, query)
// and returns exactly one result beat per command, in order. The edge that
// accepts a command also captures its count and free-FIFO reads into the
// command stage, and the result is registered when the stage advances.
// Throughput is one command per cycle unless cmd_stall is high, set by the
// single read-modify-write of the count RAM; back-to-back commands on the
// same handle are forwarded from the last write. The result register lets a
// new command enter while a result waits on rsp_stall. After reset the count
// RAM is zeroed by a clearing pass over every entry, during which cmd_stall
// stays high. Handles above 31 can be allocated when NUM_BUFFERS is larger
// than 32, but only the low five bits are reported.
// ----------------------------------------------------------------------------
module refcounted_buffer_pool_core
	import rbp_pkg::*;
#(
	parameter int NUM_BUFFERS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  rbp_in_t  cmd,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rbp_out_t rsp
);

	localparam int AW = $clog2(NUM_BUFFERS);
	localparam int LW = $clog2(NUM_BUFFERS + 1);
	localparam int XW = (AW > HANDLE_W) ? AW : HANDLE_W;
	localparam int CW = (LW > LEVEL_W) ? LW : LEVEL_W;
	localparam logic [AW-1:0] LAST = AW'(NUM_BUFFERS - 1);

	// count RAM and its clearing pass
	logic [COUNT_W-1:0] cnt_mem [NUM_BUFFERS];
	logic               clr_q;
	logic [AW-1:0]      clr_idx_q;

	// command stage
	logic               s1_valid_q;
	cmd_t               cmd_s1;
	logic [HANDLE_W-1:0] hnd_s1;
	logic               hval_s1;
	logic [AW-1:0]      haddr_s1;
	logic [COUNT_W-1:0] cnt_rd_s1;

	// forwarding of the last count write
	logic               byp_v_q;
	logic [AW-1:0]      byp_addr_q;
	logic [COUNT_W-1:0] byp_data_q;

	logic [LW-1:0]      in_use_q, in_use_n;
	logic [DROP_W-1:0]  drops_q, drops_n;
	logic               rsp_valid_q;
	rbp_out_t           rsp_q;

	logic               accept, out_free, s1_adv, in_hval;
	logic [XW-1:0]      in_hx, gnt_x;
	logic [CW-1:0]      lvl_x, use_x;
	logic [COUNT_W-1:0] cur_cnt, cnt_o;
	status_t            status;
	logic [HANDLE_W-1:0] granted;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [COUNT_W-1:0] wr_data;

	rbp_fifo_req_t      freq;
	rbp_fifo_sts_t      fsts;
	logic [AW-1:0]      fifo_data;
	logic [LW-1:0]      fifo_level, fifo_level_n;

	// handshake: hold off during the clearing pass or while the stage is blocked
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign s1_adv    = s1_valid_q && out_free;
	assign cmd_stall = clr_q || (s1_valid_q && !out_free);
	assign accept    = cmd_valid && !cmd_stall;

	assign in_hx   = XW'(cmd.handle);
	assign in_hval = 32'(cmd.handle) < 32'(NUM_BUFFERS);

	rbp_free_fifo #(
		.NUM_BUFFERS(NUM_BUFFERS)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.adv       (s1_adv),
		.req       (freq),
		.push_data (haddr_s1),
		.head_data (fifo_data),
		.sts       (fsts),
		.level     (fifo_level),
		.level_n   (fifo_level_n)
	);

	// count seen by this command: out-of-range handles look free
	always_comb begin
		priority if (!hval_s1) begin
			cur_cnt = '0;
		end else if (byp_v_q && byp_addr_q == haddr_s1) begin
			cur_cnt = byp_data_q;
		end else begin
			cur_cnt = cnt_rd_s1;
		end
	end

	assign gnt_x = XW'(fifo_data);

	always_comb begin
		status   = ST_OK;
		granted  = hnd_s1;
		cnt_o    = '0;
		wr_en    = 1'b0;
		wr_addr  = haddr_s1;
		wr_data  = '0;
		freq     = '0;
		in_use_n = in_use_q;
		drops_n  = drops_q;
		unique case (cmd_s1)
			CMD_ALLOC: begin
				freq.pop = 1'b1;
				if (!fsts.empty) begin
					granted  = gnt_x[HANDLE_W-1:0];
					cnt_o    = COUNT_ONE;
					wr_en    = 1'b1;
					wr_addr  = fifo_data;
					wr_data  = COUNT_ONE;
					in_use_n = in_use_q + 1'b1;
				end else begin
					status  = ST_EMPTY;
					granted = '0;
					if (drops_q != DROP_MAX) begin
						drops_n = drops_q + 1'b1;
					end
				end
			end
			CMD_ADDREF: begin
				priority if (cur_cnt == '0) begin
					status = ST_FREE;
				end else if (cur_cnt == COUNT_MAX) begin
					status = ST_SAT;
					cnt_o  = COUNT_MAX;
				end else begin
					cnt_o   = cur_cnt + 1'b1;
					wr_en   = 1'b1;
					wr_data = cnt_o;
				end
			end
			CMD_RELEASE: begin
				if (cur_cnt == '0) begin
					status = ST_FREE;
				end else begin
					cnt_o   = cur_cnt - 1'b1;
					wr_en   = 1'b1;
					wr_data = cnt_o;
					if (cnt_o == '0) begin
						freq.push = 1'b1;
						if (in_use_q != '0) begin
							in_use_n = in_use_q - 1'b1;
						end
					end
				end
			end
			CMD_QUERY: begin
				cnt_o = cur_cnt;
			end
			default: begin
				cnt_o = cur_cnt;
			end
		endcase
	end

	assign lvl_x = CW'(fifo_level_n);
	assign use_x = CW'(in_use_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_idx_q   <= '0;
			s1_valid_q  <= 1'b0;
			byp_v_q     <= 1'b0;
			in_use_q    <= '0;
			drops_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == LAST) begin
					clr_q <= 1'b0;
				end
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				in_use_q    <= in_use_n;
				drops_q     <= drops_n;
				rsp_valid_q <= 1'b1;
				if (wr_en) begin
					byp_v_q <= 1'b1;
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd_t'(cmd.command);
			hnd_s1   <= cmd.handle;
			hval_s1  <= in_hval;
			haddr_s1 <= in_hx[AW-1:0];
		end
		if (s1_adv) begin
			if (wr_en) begin
				byp_addr_q <= wr_addr;
				byp_data_q <= wr_data;
			end
			rsp_q.status         <= status;
			rsp_q.granted_handle <= granted;
			rsp_q.ref_count      <= cnt_o;
			rsp_q.free_count     <= lvl_x[LEVEL_W-1:0];
			rsp_q.in_use_count   <= use_x[LEVEL_W-1:0];
			rsp_q.dropped_count  <= drops_n;
		end
	end

	// count RAM: one write port, one registered read port (read-before-write)
	always_ff @(posedge clk) begin
		if (clr_q) begin
			cnt_mem[clr_idx_q] <= '0;
		end else if (s1_adv && wr_en) begin
			cnt_mem[wr_addr] <= wr_data;
		end
		if (accept) begin
			cnt_rd_s1 <= cnt_mem[in_hx[AW-1:0]];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// every handle is either waiting in the FIFO or allocated
	a_handles_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		(LW+1)'(fifo_level) + (LW+1)'(in_use_q) == (LW+1)'(NUM_BUFFERS))
		else $error("free plus in-use count differs from pool size");

	a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !s1_valid_q)
		else $error("command in flight during count clearing");

	a_stage_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> rsp_valid_q)
		else $error("command stage advanced without a result");

	a_sat_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == ST_SAT) |-> rsp_q.ref_count == COUNT_MAX)
		else $error("saturation reported below the count ceiling");

endmodule
